// ===== sv/sae_pkg.sv =====
// Shared types, constants and helper functions of the SMTP address extractor.
// Used by sae_ctrl, sae_dp and smtp_address_extractor; depends on nothing else.
package sae_pkg;

  // Default size of the address buffer, in bytes.
  localparam int ADDRESS_LEN_DEF = 32;

  // Reset value of the SMTP port register.
  localparam logic [15:0] SMTP_PORT_RST = 16'd25;

  // Characters that the collector and the trimmer look for.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Command prefixes in lower case, left aligned in 80 bits, first character on top.
  localparam logic [79:0] PFX_MAIL  = "mail from:";
  localparam logic [79:0] PFX_RCPT  = {"rcpt to:", 16'h0000};
  localparam logic [79:0] PFX_RESET = {"reset", 40'h0000000000};

  // Command codes on the result channel.
  localparam logic [1:0] OUT_SENDER    = 2'd0;
  localparam logic [1:0] OUT_RECIPIENT = 2'd1;
  localparam logic [1:0] OUT_RESET     = 2'd2;

  // Prefix that has been matched in the current packet.
  typedef enum logic [1:0] {
    MC_NONE,
    MC_MAIL,
    MC_RCPT,
    MC_RESET
  } match_t;

  // What the accepted last byte of a packet asks for.
  typedef enum logic [1:0] {
    END_NONE,
    END_ADDR,
    END_RESET
  } end_t;

  // Address source for the buffer read port.
  typedef enum logic [1:0] {
    RD_BEG,
    RD_LAST,
    RD_EMIT
  } rd_sel_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_RUN,
    ST_LEAD_RD,
    ST_LEAD_CHK,
    ST_TRAIL_RD,
    ST_TRAIL_CHK,
    ST_BR_RD_B,
    ST_BR_CHK_B,
    ST_BR_RD_E,
    ST_BR_CHK_E,
    ST_EM_START,
    ST_EM_RD,
    ST_EM_OUT,
    ST_EM_EMPTY,
    ST_RST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    take;
    rd_sel_t rd_sel;
    logic    beg_inc;
    logic    end_dec;
    logic    pos_clr;
    logic    load_byte;
    logic    load_empty;
    logic    load_reset;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    end_t end_kind;
    logic beg_lt_end;
    logic span_gt1;
    logic rd_space;
    logic rd_lt;
    logic rd_gt;
    logic out_free;
    logic emit_last;
  } dp_stat_t;

  // Fold upper-case letters to lower case.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Length of prefix k (0 MAIL, 1 RCPT, 2 RESET).
  function automatic logic [3:0] prefix_size(input logic [1:0] k);
    logic [3:0] r;
    case (k)
      2'd0:    r = 4'd10;
      2'd1:    r = 4'd8;
      2'd2:    r = 4'd5;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Character p of prefix k; positions past the prefix read as zero.
  function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [3:0] p);
    logic [79:0] txt;
    logic [79:0] sh;
    case (k)
      2'd0:    txt = PFX_MAIL;
      2'd1:    txt = PFX_RCPT;
      2'd2:    txt = PFX_RESET;
      default: txt = '0;
    endcase
    sh = txt << {p, 3'b000};
    return sh[79:72];
  endfunction

endpackage

// ===== sv/sae_ctrl.sv =====
// Controller of the SMTP address extractor: sequences byte intake, trimming and emission.
// Depends on sae_pkg; drives sae_dp through dp_cmd_t and watches dp_stat_t.
module sae_ctrl
  import sae_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (in_tvalid) begin
          if (stat.end_kind == END_ADDR) begin
            state_nxt = ST_LEAD_RD;
          end else if (stat.end_kind == END_RESET) begin
            state_nxt = ST_RST_OUT;
          end
        end
      end
      ST_LEAD_RD:   state_nxt = stat.beg_lt_end ? ST_LEAD_CHK : ST_TRAIL_RD;
      ST_LEAD_CHK:  state_nxt = stat.rd_space ? ST_LEAD_RD : ST_TRAIL_RD;
      ST_TRAIL_RD:  state_nxt = stat.beg_lt_end ? ST_TRAIL_CHK : ST_BR_RD_B;
      ST_TRAIL_CHK: state_nxt = stat.rd_space ? ST_TRAIL_RD : ST_BR_RD_B;
      ST_BR_RD_B:   state_nxt = stat.span_gt1 ? ST_BR_CHK_B : ST_EM_START;
      ST_BR_CHK_B:  state_nxt = stat.rd_lt ? ST_BR_RD_E : ST_EM_START;
      ST_BR_RD_E:   state_nxt = ST_BR_CHK_E;
      ST_BR_CHK_E:  state_nxt = ST_EM_START;
      ST_EM_START:  state_nxt = stat.beg_lt_end ? ST_EM_RD : ST_EM_EMPTY;
      ST_EM_RD:     state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (stat.out_free) begin
          state_nxt = stat.emit_last ? ST_RUN : ST_EM_RD;
        end
      end
      ST_EM_EMPTY: begin
        if (stat.out_free) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RST_OUT: begin
        if (stat.out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_BEG;
    in_tready = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_LEAD_RD:   cmd.rd_sel = RD_BEG;
      ST_LEAD_CHK:  cmd.beg_inc = stat.rd_space;
      ST_TRAIL_RD:  cmd.rd_sel = RD_LAST;
      ST_TRAIL_CHK: cmd.end_dec = stat.rd_space;
      ST_BR_RD_B:   cmd.rd_sel = RD_BEG;
      ST_BR_CHK_B:  cmd.rd_sel = RD_BEG;
      ST_BR_RD_E:   cmd.rd_sel = RD_LAST;
      ST_BR_CHK_E: begin
        cmd.beg_inc = stat.rd_gt;
        cmd.end_dec = stat.rd_gt;
      end
      ST_EM_START:  cmd.pos_clr = 1'b1;
      ST_EM_RD:     cmd.rd_sel = RD_EMIT;
      ST_EM_OUT: begin
        // Keep the read address steady so the data holds while the output waits.
        cmd.rd_sel    = RD_EMIT;
        cmd.load_byte = stat.out_free;
      end
      ST_EM_EMPTY:  cmd.load_empty = stat.out_free;
      ST_RST_OUT:   cmd.load_reset = stat.out_free;
      default:      cmd.rd_sel = RD_BEG;
    endcase
  end

endmodule

// ===== sv/sae_dp.sv =====
// Datapath of the SMTP address extractor: packet filter, prefix matcher, address buffer,
// trim pointers and output register. Depends on sae_pkg; steered by sae_ctrl.
module sae_dp
  import sae_pkg::*;
#(
  parameter int ADDRESS_LEN = ADDRESS_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam int W  = $clog2(ADDRESS_LEN + 1);
  localparam int AW = $clog2(ADDRESS_LEN);
  localparam int XW = W + 6;

  // Input fields.
  logic [7:0]  in_byte;
  logic        in_first;
  logic        in_tcp;
  logic [15:0] in_sport;
  logic [15:0] in_dport;

  assign in_byte  = in_tdata[7:0];
  assign in_sport = in_tdata[23:8];
  assign in_dport = in_tdata[39:24];
  assign in_first = in_tuser[0];
  assign in_tcp   = in_tuser[1];

  // Configuration and per-packet state.
  logic [15:0]  port_r;
  logic         acc_r, acc_e;
  logic [3:0]   ppos_r, ppos_e, ppos_nxt;
  logic [2:0]   cand_r, cand_e, cand_nxt;
  match_t       match_r, match_e, match_nxt;
  logic [W-1:0] fill_r, fill_e, fill_nxt;
  logic         closed_r, closed_e, closed_nxt;
  logic         wr_en;
  logic [7:0]   low_byte;
  logic [2:0]   alive;
  end_t         end_kind;

  // Trim and emit pointers.
  logic [W-1:0]  beg_r, end_r, pos_r;
  logic [W-1:0]  len_w, end_m1, emit_addr, pos_p1;
  logic [1:0]    ecmd_r;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem [ADDRESS_LEN];
  logic [XW-1:0] pos_x, len_x;

  // Output register.
  logic       out_valid_r;
  logic [1:0] out_cmd_r;
  logic [7:0] out_byte_r;
  logic [4:0] out_pos_r;
  logic [5:0] out_len_r;
  logic       out_last_r;
  logic       load_any;

  // Port register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r <= SMTP_PORT_RST;
    end else if (cfg_we) begin
      port_r <= cfg_data;
    end
  end

  // Packet start, prefix matching and address collection for one byte.
  always_comb begin
    acc_e    = acc_r;
    ppos_e   = ppos_r;
    cand_e   = cand_r;
    match_e  = match_r;
    fill_e   = fill_r;
    closed_e = closed_r;
    if (in_first) begin
      acc_e    = in_tcp && (in_sport == port_r || in_dport == port_r);
      ppos_e   = '0;
      cand_e   = 3'b111;
      match_e  = MC_NONE;
      fill_e   = '0;
      closed_e = 1'b0;
    end
    ppos_nxt   = ppos_e;
    cand_nxt   = cand_e;
    match_nxt  = match_e;
    fill_nxt   = fill_e;
    closed_nxt = closed_e;
    wr_en      = 1'b0;
    low_byte   = fold_case(in_byte);
    alive      = '0;
    if (acc_e) begin
      if (match_e == MC_NONE) begin
        for (int k = 0; k < 3; k++) begin
          if (cand_e[k] && ppos_e < prefix_size(2'(k)) &&
              low_byte == prefix_char(2'(k), ppos_e)) begin
            alive[k] = 1'b1;
          end
        end
        cand_nxt = alive;
        ppos_nxt = (ppos_e == 4'hF) ? ppos_e : ppos_e + 4'd1;
        for (int k = 0; k < 3; k++) begin
          if (alive[k] && ppos_nxt == prefix_size(2'(k))) begin
            match_nxt = match_t'(2'(k + 1));
          end
        end
      end else if (match_e == MC_MAIL || match_e == MC_RCPT) begin
        if (!closed_e && fill_e < W'(ADDRESS_LEN)) begin
          if (in_byte == CH_CR || in_byte == CH_LF || in_byte == CH_NUL) begin
            closed_nxt = 1'b1;
          end else begin
            wr_en    = 1'b1;
            fill_nxt = fill_e + 1'b1;
            if (in_byte == CH_GT) begin
              closed_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  // Per-packet state registers; the last byte of a packet clears them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 1'b0;
      ppos_r   <= '0;
      cand_r   <= 3'b111;
      match_r  <= MC_NONE;
      fill_r   <= '0;
      closed_r <= 1'b0;
    end else if (cmd.take) begin
      if (in_tlast) begin
        acc_r    <= 1'b0;
        ppos_r   <= '0;
        cand_r   <= 3'b111;
        match_r  <= MC_NONE;
        fill_r   <= '0;
        closed_r <= 1'b0;
      end else begin
        acc_r    <= acc_e;
        ppos_r   <= ppos_nxt;
        cand_r   <= cand_nxt;
        match_r  <= match_nxt;
        fill_r   <= fill_nxt;
        closed_r <= closed_nxt;
      end
    end
  end

  // Kind of work the accepted last byte leaves behind.
  always_comb begin
    end_kind = END_NONE;
    if (acc_e && in_tlast) begin
      case (match_nxt)
        MC_MAIL, MC_RCPT: end_kind = END_ADDR;
        MC_RESET:         end_kind = END_RESET;
        default:          end_kind = END_NONE;
      endcase
    end
  end

  // Trim window and emit position.
  always_ff @(posedge clk) begin
    if (cmd.take && in_tlast) begin
      beg_r  <= '0;
      end_r  <= fill_nxt;
      ecmd_r <= (match_nxt == MC_RCPT) ? OUT_RECIPIENT : OUT_SENDER;
    end else begin
      if (cmd.beg_inc) begin
        beg_r <= beg_r + 1'b1;
      end
      if (cmd.end_dec) begin
        end_r <= end_m1;
      end
    end
    if (cmd.pos_clr) begin
      pos_r <= '0;
    end else if (cmd.load_byte) begin
      pos_r <= pos_p1;
    end
  end

  assign len_w     = end_r - beg_r;
  assign end_m1    = end_r - 1'b1;
  assign emit_addr = beg_r + pos_r;
  assign pos_p1    = pos_r + 1'b1;

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_LAST: rd_addr = end_m1[AW-1:0];
      RD_EMIT: rd_addr = emit_addr[AW-1:0];
      default: rd_addr = beg_r[AW-1:0];
    endcase
  end

  // Address buffer: one write port for collection, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[fill_e[AW-1:0]] <= in_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Status to the controller.
  assign stat.end_kind   = end_kind;
  assign stat.beg_lt_end = (len_w != '0);
  assign stat.span_gt1   = (len_w > W'(1));
  assign stat.rd_space   = (rd_data_r == CH_SPACE);
  assign stat.rd_lt      = (rd_data_r == CH_LT);
  assign stat.rd_gt      = (rd_data_r == CH_GT);
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.emit_last  = (pos_p1 == len_w);

  assign pos_x    = XW'(pos_r);
  assign len_x    = XW'(len_w);
  assign load_any = cmd.load_byte || cmd.load_empty || cmd.load_reset;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_any) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_cmd_r  <= ecmd_r;
      out_byte_r <= rd_data_r;
      out_pos_r  <= pos_x[4:0];
      out_len_r  <= len_x[5:0];
      out_last_r <= stat.emit_last;
    end else if (cmd.load_empty || cmd.load_reset) begin
      out_cmd_r  <= cmd.load_reset ? OUT_RESET : ecmd_r;
      out_byte_r <= '0;
      out_pos_r  <= '0;
      out_len_r  <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_len_r, out_pos_r, out_byte_r};
  assign out_tuser  = out_cmd_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/smtp_address_extractor.sv =====
// Top level of the SMTP address extractor: stream ports, configuration port and checks.
// Depends on sae_pkg, sae_ctrl and sae_dp.
//
// The block takes one TCP payload byte per cycle while it collects a packet, keeps only
// packets whose source or destination port equals the port register, and recognizes the
// "MAIL From:", "RCPT To:" and "RESET" prefixes in any case. When the last byte of a packet
// with an address arrives, input is held off while the address is trimmed and sent out:
// the address buffer has a single read port, so each trim step reads a byte and then checks
// it. Leading and trailing spaces are stripped one at a time, then an enclosing pair of
// angle brackets is checked and stripped; emission is set up and each address byte is then
// read and loaded into the output register, waiting while the result channel holds off.
// A RESET packet gives a single result. Results wait in an output register, so input
// resumes as soon as the last result of a packet is loaded.
module smtp_address_extractor
  import sae_pkg::*;
#(
  parameter int ADDRESS_LEN = ADDRESS_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: smtp_port.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Payload bytes.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // payload_byte[7:0], source_port[23:8], dest_port[39:24]
  input  logic [1:0]  in_tuser,   // first_byte[0], is_tcp[1]
  input  logic        in_tlast,   // last_byte
  // Address results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // address_byte[7:0], byte_position[12:8],
                                  // address_length[18:13], zero[23:19]
  output logic [1:0]  out_tuser,  // command[1:0]
  output logic        out_tlast   // last_result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The port register is always writable.
  assign cfg_ready = 1'b1;

  // Controller.
  sae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  sae_dp #(
    .ADDRESS_LEN(ADDRESS_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`ifndef ASSERT_OFF
  // A reset request is a single, empty, final result.
  a_reset_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == OUT_RESET |-> out_tlast && out_tdata[18:0] == 19'd0)
    else $error("reset result is not a lone empty transaction");

  // Every result but the last of an address lies inside the address.
  a_pos_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast && ADDRESS_LEN <= 32 |->
      {1'b0, out_tdata[12:8]} < out_tdata[18:13])
    else $error("byte position beyond address length");

  // Input is held off from the cycle after a transaction that starts an address burst or a reset result.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && stat.end_kind != END_NONE |=> !in_tready)
    else $error("input accepted while address burst is pending");
`endif

endmodule
